// ===== src/emc_pkg.sv =====
// Shared types and constants for the espresso mode controller.
// Used by the step logic, the register file, the top level and the checker.
// Depends on nothing.
package emc_pkg;

  // Machine modes, as shown on the mode output.
  typedef enum logic [2:0] {
    MODE_UNINIT   = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_HEATING  = 3'd2,
    MODE_PREINF   = 3'd3,
    MODE_BREWING  = 3'd4,
    MODE_STEAMING = 3'd5,
    MODE_SAFETY   = 3'd6
  } mode_t;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_PREINF_SECONDS  = 3'd0,
    REG_BREW_TEMP       = 3'd1,
    REG_STEAM_TEMP      = 3'd2,
    REG_PREINF_PRESSURE = 3'd3,
    REG_BREW_PRESSURE   = 3'd4
  } reg_index_t;

  localparam int unsigned TARGET_W  = 11;
  localparam int unsigned SECONDS_W = 6;
  localparam int unsigned LIMIT_W   = 16;

  localparam logic [LIMIT_W-1:0] MS_PER_SECOND = 16'd1000;

  // Configuration register contents.
  typedef struct packed {
    logic [SECONDS_W-1:0] preinfusion_seconds;
    logic [TARGET_W-1:0]  brew_temperature;
    logic [TARGET_W-1:0]  steam_temperature;
    logic [TARGET_W-1:0]  preinfusion_pressure;
    logic [TARGET_W-1:0]  brew_pressure;
  } cfg_t;

  // One controller tick as taken from the input channel.
  typedef struct packed {
    logic        power_press;
    logic        pump_switch;
    logic        steam_switch;
    logic        temp_anomaly;
    logic [31:0] now_ms;
  } tick_t;

  // Controller state; the drive and target fields are also the result word.
  typedef struct packed {
    mode_t               mode;
    logic [31:0]         preinfusion_start;
    logic                heater;
    logic                solenoid;
    logic                power_light;
    logic                pump_light;
    logic                steam_light;
    logic [TARGET_W-1:0] pressure;
    logic [TARGET_W-1:0] temperature;
  } state_t;

endpackage

// ===== src/emc_regs.sv =====
// Configuration register file of the espresso mode controller, on an APB-style port.
// Depends on emc_pkg for the register indexes and the cfg_t struct.
module emc_regs
  import emc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[4:2]);

  // Register writes; reset loads the default targets.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preinfusion_seconds  <= 6'd3;
      cfg.brew_temperature     <= 11'd930;
      cfg.steam_temperature    <= 11'd1300;
      cfg.preinfusion_pressure <= 11'd200;
      cfg.brew_pressure        <= 11'd900;
    end else if (wr_en) begin
      unique case (idx)
        REG_PREINF_SECONDS:  cfg.preinfusion_seconds  <= pwdata[SECONDS_W-1:0];
        REG_BREW_TEMP:       cfg.brew_temperature     <= pwdata[TARGET_W-1:0];
        REG_STEAM_TEMP:      cfg.steam_temperature    <= pwdata[TARGET_W-1:0];
        REG_PREINF_PRESSURE: cfg.preinfusion_pressure <= pwdata[TARGET_W-1:0];
        REG_BREW_PRESSURE:   cfg.brew_pressure        <= pwdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_PREINF_SECONDS:  prdata = {26'd0, cfg.preinfusion_seconds};
      REG_BREW_TEMP:       prdata = {21'd0, cfg.brew_temperature};
      REG_STEAM_TEMP:      prdata = {21'd0, cfg.steam_temperature};
      REG_PREINF_PRESSURE: prdata = {21'd0, cfg.preinfusion_pressure};
      REG_BREW_PRESSURE:   prdata = {21'd0, cfg.brew_pressure};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/emc_step.sv =====
// Next-state logic of the espresso mode controller for one tick.
// Depends on emc_pkg for mode_t, cfg_t, tick_t and state_t.
module emc_step
  import emc_pkg::*;
(
  input  state_t cur,
  input  cfg_t   cfg,
  input  tick_t  tick,
  output state_t nxt
);

  logic [31:0]        elapsed;
  logic [LIMIT_W-1:0] limit;
  logic               preinf_done;

  // Elapsed preinfusion time against the configured duration.
  assign elapsed     = tick.now_ms - cur.preinfusion_start;
  assign limit       = LIMIT_W'(LIMIT_W'(cfg.preinfusion_seconds) * MS_PER_SECOND);
  assign preinf_done = elapsed > {16'd0, limit};

  always_comb begin
    nxt = cur;

    // The anomaly check runs first and latches safety off.
    if (tick.temp_anomaly && cur.mode != MODE_SAFETY) begin
      nxt.heater   = 1'b0;
      nxt.solenoid = 1'b1;
      nxt.mode     = MODE_SAFETY;
    end

    unique case (nxt.mode)
      MODE_UNINIT: begin
        nxt.mode = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (tick.power_press) begin
          nxt.power_light = 1'b1;
          nxt.heater      = 1'b1;
          nxt.pump_light  = 1'b0;
          nxt.steam_light = 1'b0;
          nxt.pressure    = '0;
          nxt.solenoid    = 1'b0;
          nxt.temperature = cfg.brew_temperature;
          nxt.mode        = MODE_HEATING;
        end
      end
      MODE_HEATING: begin
        if (tick.power_press) begin
          nxt.power_light = 1'b0;
          nxt.pump_light  = 1'b0;
          nxt.steam_light = 1'b0;
          nxt.solenoid    = 1'b0;
          nxt.heater      = 1'b0;
          nxt.pressure    = '0;
          nxt.temperature = '0;
          nxt.mode        = MODE_IDLE;
        end else if (tick.pump_switch) begin
          nxt.pump_light        = 1'b1;
          nxt.pressure          = cfg.preinfusion_pressure;
          nxt.solenoid          = 1'b1;
          nxt.preinfusion_start = tick.now_ms;
          nxt.mode              = MODE_PREINF;
        end else if (tick.steam_switch) begin
          nxt.steam_light = 1'b1;
          nxt.pressure    = '0;
          nxt.solenoid    = 1'b0;
          nxt.temperature = cfg.steam_temperature;
          nxt.mode        = MODE_STEAMING;
        end
      end
      MODE_PREINF, MODE_BREWING, MODE_STEAMING: begin
        if (tick.power_press) begin
          nxt.power_light = 1'b0;
          nxt.pump_light  = 1'b0;
          nxt.steam_light = 1'b0;
          nxt.solenoid    = 1'b0;
          nxt.heater      = 1'b0;
          nxt.pressure    = '0;
          nxt.temperature = '0;
          nxt.mode        = MODE_IDLE;
        end else if ((nxt.mode == MODE_STEAMING) ? !tick.steam_switch
                                                  : !tick.pump_switch) begin
          // Switch released: fall back to heating.
          nxt.pump_light  = 1'b0;
          nxt.steam_light = 1'b0;
          nxt.pressure    = '0;
          nxt.solenoid    = 1'b0;
          nxt.temperature = cfg.brew_temperature;
          nxt.mode        = MODE_HEATING;
        end else if (nxt.mode == MODE_PREINF && preinf_done) begin
          nxt.pressure = cfg.brew_pressure;
          nxt.mode     = MODE_BREWING;
        end
      end
      default: ;  // Safety off holds until reset.
    endcase
  end

endmodule

// ===== src/espresso_mode_controller.sv =====
// Top level of the espresso mode controller: input register, step logic, state/result register.
// Depends on emc_pkg, emc_regs and emc_step.
//
// Takes one controller tick per clock cycle when the result side keeps up. A tick is
// held in an input register; then the mode decode, the 32-bit elapsed time subtract
// and compare, and the target selection update the state register, which drives the
// result word directly. A tick's result is written into the state register once the
// input register can advance. in_stall rises only while a result waits on out_stall and
// another tick already sits in the input register. Configuration registers are written
// through the APB-style port and take effect for the next tick.
module espresso_mode_controller
  import emc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        power_press,
  input  logic        pump_switch,
  input  logic        steam_switch,
  input  logic        temp_anomaly,
  input  logic [31:0] now_ms,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  mode,
  output logic        heater_on,
  output logic        solenoid_open,
  output logic        power_light,
  output logic        pump_light,
  output logic        steam_light,
  output logic [10:0] pressure_target,
  output logic [10:0] temperature_target
);

  cfg_t   cfg;
  tick_t  s1_tick;
  logic   s1_valid;
  state_t state;
  state_t state_next;
  logic   out_free;
  logic   advance;

  // Configuration registers.
  emc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-tick mode logic.
  emc_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .tick (s1_tick),
    .nxt  (state_next)
  );

  // Handshake: the result register frees up when empty or when its word is taken.
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick.power_press  <= power_press;
      s1_tick.pump_switch  <= pump_switch;
      s1_tick.steam_switch <= steam_switch;
      s1_tick.temp_anomaly <= temp_anomaly;
      s1_tick.now_ms       <= now_ms;
    end
  end

  // The state register is the result word.
  assign mode               = state.mode;
  assign heater_on          = state.heater;
  assign solenoid_open      = state.solenoid;
  assign power_light        = state.power_light;
  assign pump_light         = state.pump_light;
  assign steam_light        = state.steam_light;
  assign pressure_target    = state.pressure;
  assign temperature_target = state.temperature;

endmodule

// ===== src/emc_checker.sv =====
// Port-level checker for the espresso mode controller, bound to the top level.
// Depends on emc_pkg for the mode codes.
module emc_assertions
  import emc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  mode,
  input logic        heater_on,
  input logic        solenoid_open,
  input logic        power_light,
  input logic [10:0] pressure_target
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode) && $stable(pressure_target))
    else $error("result word changed while stalled");

  // Safety off is latched until reset.
  a_safety_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_SAFETY |=> mode == MODE_SAFETY)
    else $error("left safety off without reset");

  // In safety off the heater is off and the solenoid is open.
  a_safety_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_SAFETY |-> !heater_on && solenoid_open)
    else $error("unsafe drive in safety off");

  // Idle means everything is switched off.
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_IDLE |->
      !heater_on && !solenoid_open && !power_light && pressure_target == 11'd0)
    else $error("drive active while idle");

  // No word is presented in the cycle after a reset edge.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word valid right after reset");

endmodule

bind espresso_mode_controller emc_assertions u_emc_assertions (.*);
